// ----- rtl/core/smms_pkg.sv -----
package smms_pkg;
  localparam int MaxSamples = 1024;
  localparam int AddrW = 10;
  localparam int CntW = 11;
  localparam int ValW = 24;
  localparam int SumW = 34;
  localparam int SqW = 68;
  localparam int QDepth = 4;
  localparam int QPtrW = 2;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   last;
  } smms_item_t;
endpackage

// ----- rtl/core/smms_queue.sv -----
module smms_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  smms_pkg::smms_item_t push_item,
  input  logic               pop,
  output smms_pkg::smms_item_t pop_item,
  output logic               empty,
  output logic               full
);
  import smms_pkg::*;

  smms_item_t         mem_r [QDepth];
  logic [QPtrW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPtrW:0]     cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (QPtrW+1)'(QDepth));
  assign pop_item = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r + QPtrW'(push);
    rd_nxt  = rd_r + QPtrW'(pop);
    cnt_nxt = cnt_r + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
    if (!rst_n) begin
      wr_r <= '0; rd_r <= '0; cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt; rd_r <= rd_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule

// ----- rtl/core/smms_div.sv -----
module smms_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [smms_pkg::SqW-1:0]  dividend,
  input  logic [smms_pkg::CntW-1:0] divisor,
  output logic              done,
  output logic [smms_pkg::SqW-1:0]  quotient
);
  import smms_pkg::*;

  localparam int StepW = $clog2(SqW+1);

  logic [SqW-1:0]   q_r, q_nxt;
  logic [CntW:0]    rem_r, rem_nxt;
  logic [CntW-1:0]  d_r;
  logic [StepW-1:0] step_r, step_nxt;
  logic             busy_r, busy_nxt, done_nxt;
  logic [CntW:0]    trial;

  assign quotient = q_r;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; step_nxt = step_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = '0;
    if (go) begin
      q_nxt = dividend; rem_nxt = '0; step_nxt = StepW'(SqW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r[CntW-1:0], q_r[SqW-1]};
      q_nxt = {q_r[SqW-2:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      step_nxt = step_r - 1'b1;
      if (step_r == StepW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (go) d_r <= divisor;
    if (!rst_n) begin
      step_r <= '0; busy_r <= 1'b0; done <= 1'b0;
    end else begin
      step_r <= step_nxt; busy_r <= busy_nxt; done <= done_nxt;
    end
  end
endmodule

// ----- rtl/core/smms_back.sv -----
module smms_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  smms_pkg::smms_item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic [10:0]          out_sample_count,
  output logic signed [23:0]   out_min_value,
  output logic signed [23:0]   out_max_value,
  output logic signed [23:0]   out_mean_value,
  output logic [23:0]          out_std_dev,
  output logic                 out_overflow_flag
);
  import smms_pkg::*;

  localparam logic [3:0] S_LOAD = 4'd0, S_MDIV = 4'd1, S_MWAIT = 4'd2,
                         S_RD = 4'd3, S_SUB = 4'd4, S_SQ = 4'd5, S_ACC = 4'd6,
                         S_VDIV = 4'd7, S_VWAIT = 4'd8, S_SQRT = 4'd9, S_OUT = 4'd10;
  localparam int RootSteps = SqW / 2;
  localparam int RsW = $clog2(RootSteps+1);

  logic [3:0] st_r, st_nxt;
  logic signed [ValW-1:0] store [MaxSamples];
  logic [CntW-1:0]        cnt_r;
  logic signed [ValW-1:0] min_r, max_r;
  logic signed [SumW-1:0] sum_r;
  logic                   drop_r;
  logic [CntW-1:0]        idx_r;
  logic signed [ValW-1:0] rd_r;
  logic signed [SumW-1:0] mean_r;
  logic signed [SumW-1:0] diff_r;
  logic [SqW-1:0]         sq_r, acc_r;
  logic                   sum_neg_r;

  // Divider is shared between the mean and the variance steps.
  logic            div_go, div_done;
  logic [SqW-1:0]  div_a, div_q;
  smms_div u_div (.clk, .rst_n, .go(div_go), .dividend(div_a), .divisor(cnt_r),
                  .done(div_done), .quotient(div_q));

  // Bitwise floor square root, two bits of the radicand a cycle.
  logic [SqW-1:0] rad_r, rem_r;
  logic [RsW-1:0] rs_r;
  logic [SqW/2-1:0] root_r;
  logic [SqW/2+1:0] rtrial, rcur;

  logic signed [ValW-1:0] x;
  logic                   room;
  logic [SumW-1:0]        abs_sum;
  // A sample and the mean both lie in the sample range, so the distance fits ValW bits.
  logic [ValW-1:0]        diff_mag;
  logic [2*ValW-1:0]      sq_prod;

  assign x = q_item.value;
  assign room = (cnt_r != CntW'(MaxSamples));
  assign q_pop = (st_r == S_LOAD) && !q_empty;
  assign abs_sum = sum_r[SumW-1] ? SumW'(-sum_r) : SumW'(sum_r);
  assign diff_mag = diff_r[SumW-1] ? ValW'(-diff_r) : ValW'(diff_r);
  assign sq_prod = diff_mag * diff_mag;
  assign div_go = (st_r == S_MDIV) || (st_r == S_VDIV);
  assign div_a = (st_r == S_MDIV) ? SqW'(abs_sum) : acc_r;
  assign rcur = {rem_r[SqW/2-1:0], rad_r[SqW-1 -: 2]};
  assign rtrial = {root_r, 2'b01};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_LOAD:  if (q_pop && q_item.last) st_nxt = S_MDIV;
      S_MDIV:  st_nxt = S_MWAIT;
      S_MWAIT: if (div_done) st_nxt = S_RD;
      S_RD:    st_nxt = S_SUB;
      S_SUB:   st_nxt = S_SQ;
      S_SQ:    st_nxt = S_ACC;
      S_ACC:   st_nxt = (idx_r == cnt_r) ? S_VDIV : S_RD;
      S_VDIV:  st_nxt = S_VWAIT;
      S_VWAIT: if (div_done) st_nxt = S_SQRT;
      S_SQRT:  if (rs_r == RsW'(1)) st_nxt = S_OUT;
      S_OUT:   st_nxt = S_LOAD;
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && room) store[cnt_r[AddrW-1:0]] <= x;
    rd_r <= store[idx_r[AddrW-1:0]];
    if (st_r == S_MWAIT && div_done) begin
      mean_r <= sum_neg_r ? -SumW'(div_q) : SumW'(div_q);
      idx_r  <= '0;
      acc_r  <= '0;
    end
    if (st_r == S_RD) idx_r <= idx_r + 1'b1;
    if (st_r == S_SUB) diff_r <= SumW'(rd_r) - mean_r;
    if (st_r == S_SQ) sq_r <= SqW'(sq_prod);
    if (st_r == S_ACC) acc_r <= acc_r + sq_r;
    if (st_r == S_MDIV) sum_neg_r <= sum_r[SumW-1];
    if (st_r == S_VWAIT && div_done) begin
      rad_r <= div_q; rem_r <= '0; root_r <= '0; rs_r <= RsW'(RootSteps);
    end
    if (st_r == S_SQRT) begin
      rad_r <= {rad_r[SqW-3:0], 2'b00};
      rs_r  <= rs_r - 1'b1;
      if (rcur >= rtrial) begin
        rem_r  <= SqW'(rcur - rtrial);
        root_r <= {root_r[SqW/2-2:0], 1'b1};
      end else begin
        rem_r  <= SqW'(rcur);
        root_r <= {root_r[SqW/2-2:0], 1'b0};
      end
    end
    if (!rst_n) begin
      st_r <= S_LOAD; cnt_r <= '0; min_r <= '0; max_r <= '0; sum_r <= '0;
      drop_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid <= 1'b0;
      if (q_pop) begin
        if (room) begin
          if (cnt_r == '0 || x < min_r) min_r <= x;
          if (cnt_r == '0 || x > max_r) max_r <= x;
          sum_r <= sum_r + SumW'(x);
          cnt_r <= cnt_r + 1'b1;
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (st_r == S_OUT) begin
        out_valid         <= 1'b1;
        out_sample_count  <= cnt_r;
        out_min_value     <= min_r;
        out_max_value     <= max_r;
        out_mean_value    <= ValW'(mean_r);
        out_std_dev       <= (root_r > (SqW/2)'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(root_r);
        out_overflow_flag <= drop_r;
        cnt_r <= '0; min_r <= '0; max_r <= '0; sum_r <= '0; drop_r <= 1'b0;
      end
    end
  end
endmodule

// ----- rtl/core/sample_min_max_mean_stddev.sv -----
// Sample set statistics: count, minimum, maximum, mean and population deviation.
// Input: a transaction is taken when start is high and busy is low, carrying
// in_sample_value (signed Q7.16) and in_last_sample, which closes the set.
// Transactions go into a four-entry queue; the back end drains it, one sample
// per cycle while it is collecting a set, into a 1024-entry sample memory
// while keeping min, max and sum. busy is high while the queue is full.
// After the last sample the back end divides the sum (bit-serial divider),
// makes a second pass over the memory with each stored sample taken through
// memory read, subtract, square and accumulate, divides again and takes a
// square root, then shows the result for one cycle with out_valid. The queue
// fills and start is held off meanwhile.
// Results cannot be stalled by the receiver. Samples past the memory capacity
// are dropped and reported through out_overflow_flag.
// Reset (synchronous, rst_n low) empties the queue and starts an empty set.
module sample_min_max_mean_stddev (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [23:0]  in_sample_value,
  input  logic                in_last_sample,
  output logic                out_valid,
  output logic [10:0]         out_sample_count,
  output logic signed [23:0]  out_min_value,
  output logic signed [23:0]  out_max_value,
  output logic signed [23:0]  out_mean_value,
  output logic [23:0]         out_std_dev,
  output logic                out_overflow_flag
);
  import smms_pkg::*;

  smms_item_t in_item, q_item;
  logic q_full, q_empty, q_pop;

  assign busy = q_full;
  assign in_item = '{value: in_sample_value, last: in_last_sample};

  smms_queue u_queue (.clk, .rst_n, .push(start && !q_full), .push_item(in_item),
                      .pop(q_pop), .pop_item(q_item), .empty(q_empty), .full(q_full));

  smms_back u_back (.clk, .rst_n, .q_empty, .q_item, .q_pop, .out_valid,
                    .out_sample_count, .out_min_value, .out_max_value,
                    .out_mean_value, .out_std_dev, .out_overflow_flag);
endmodule

// ----- rtl/core/smms_checker.sv -----
module smms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [10:0] out_sample_count,
  input logic signed [23:0] out_min_value,
  input logic signed [23:0] out_max_value,
  input logic signed [23:0] out_mean_value
);
  // A result is one cycle wide, so two results never touch.
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_value <= out_max_value) else $error("min above max");
  a_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mean_value >= out_min_value && out_mean_value <= out_max_value))
    else $error("mean outside range");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample_count != 11'd0) else $error("empty result");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("outputs active after reset");
endmodule

bind sample_min_max_mean_stddev smms_checker u_smms_checker (.clk, .rst_n, .busy,
  .out_valid, .out_sample_count, .out_min_value, .out_max_value, .out_mean_value);
